// ===== rtl/sfba_pkg.sv =====
// ----------------------------------------------------------------------------
// sfba_pkg
// shared types, constants and projection table for the face bounds block
// ----------------------------------------------------------------------------
package sfba_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int COORD_W      = 28;
  localparam int PICK_W       = COORD_W + 1;
  localparam int SUM_W        = COORD_W + ADDR_W;
  localparam int BOUND_W      = 24;
  localparam int FRAC_SHIFT   = 16;
  localparam int DIVIDEND_W   = COORD_W + FRAC_SHIFT;
  localparam int DIV_CNT_W    = $clog2(DIVIDEND_W + 1);
  localparam int NUM_FACES    = 6;

  localparam logic signed [BOUND_W-1:0] BOUND_MAX = {1'b0, {(BOUND_W-1){1'b1}}};
  localparam logic signed [BOUND_W-1:0] BOUND_MIN = {1'b1, {(BOUND_W-1){1'b0}}};
  localparam logic signed [PICK_W-1:0]  DEPTH_MIN = PICK_W'(4);
  localparam logic [2:0]                FACE_LAST = 3'd5;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  typedef struct packed {
    logic  neg;
    axis_e axis;
  } col_code_t;

  typedef struct packed {
    logic [1:0]                 opcode;
    logic signed [COORD_W-1:0]  coord_x;
    logic signed [COORD_W-1:0]  coord_y;
    logic signed [COORD_W-1:0]  coord_z;
    logic                       last_vertex;
    logic [2:0]                 face_select;
  } in_word_t;

  typedef struct packed {
    logic [2:0]                 face;
    logic signed [BOUND_W-1:0]  s_low;
    logic signed [BOUND_W-1:0]  t_low;
    logic signed [BOUND_W-1:0]  s_high;
    logic signed [BOUND_W-1:0]  t_high;
    logic                       visible;
    logic                       overflow;
  } out_word_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic signed [COORD_W-1:0]  z;
  } vertex_t;

  typedef struct packed {
    logic signed [BOUND_W-1:0]  s_low;
    logic signed [BOUND_W-1:0]  t_low;
    logic signed [BOUND_W-1:0]  s_high;
    logic signed [BOUND_W-1:0]  t_high;
  } bounds_t;

  typedef struct packed {
    logic                       start;
    logic                       neg;
    logic [DIVIDEND_W-1:0]      dividend;
    logic [COORD_W-1:0]         divisor;
  } div_req_t;

  typedef struct packed {
    logic                       done;
    logic signed [BOUND_W-1:0]  quotient;
  } div_rsp_t;

  // column 0 = s, 1 = t, 2 = depth
  function automatic col_code_t proj_col(input logic [2:0] face, input logic [1:0] col);
    col_code_t c;
    c = '{neg: 1'b0, axis: AXIS_Z};
    unique case ({face, col})
      {3'd0, 2'd0}: c = '{1'b1, AXIS_Y};
      {3'd0, 2'd1}: c = '{1'b0, AXIS_Z};
      {3'd0, 2'd2}: c = '{1'b0, AXIS_X};
      {3'd1, 2'd0}: c = '{1'b0, AXIS_Y};
      {3'd1, 2'd1}: c = '{1'b0, AXIS_Z};
      {3'd1, 2'd2}: c = '{1'b1, AXIS_X};
      {3'd2, 2'd0}: c = '{1'b0, AXIS_X};
      {3'd2, 2'd1}: c = '{1'b0, AXIS_Z};
      {3'd2, 2'd2}: c = '{1'b0, AXIS_Y};
      {3'd3, 2'd0}: c = '{1'b1, AXIS_X};
      {3'd3, 2'd1}: c = '{1'b0, AXIS_Z};
      {3'd3, 2'd2}: c = '{1'b1, AXIS_Y};
      {3'd4, 2'd0}: c = '{1'b1, AXIS_Y};
      {3'd4, 2'd1}: c = '{1'b1, AXIS_X};
      {3'd4, 2'd2}: c = '{1'b0, AXIS_Z};
      {3'd5, 2'd0}: c = '{1'b1, AXIS_Y};
      {3'd5, 2'd1}: c = '{1'b0, AXIS_X};
      {3'd5, 2'd2}: c = '{1'b1, AXIS_Z};
      default:      c = '{1'b0, AXIS_Z};
    endcase
    return c;
  endfunction

  function automatic logic signed [PICK_W-1:0] pick_coord(input vertex_t v,
                                                          input col_code_t c);
    logic signed [PICK_W-1:0] val;
    val = '0;
    unique case (c.axis)
      AXIS_X:  val = PICK_W'(v.x);
      AXIS_Y:  val = PICK_W'(v.y);
      AXIS_Z:  val = PICK_W'(v.z);
      default: val = PICK_W'(v.z);
    endcase
    return c.neg ? -val : val;
  endfunction

endpackage

// ===== rtl/sfba_vertex_ram.sv =====
// ----------------------------------------------------------------------------
// sfba_vertex_ram
// polygon vertex buffer, one write and one registered read port
// ----------------------------------------------------------------------------
module sfba_vertex_ram (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [sfba_pkg::ADDR_W-1:0] waddr_i,
  input  sfba_pkg::vertex_t         wdata_i,
  input  logic [sfba_pkg::ADDR_W-1:0] raddr_i,
  output sfba_pkg::vertex_t         rdata_o
);
  import sfba_pkg::*;

  vertex_t mem [MAX_VERTICES];
  vertex_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sfba_divider.sv =====
// ----------------------------------------------------------------------------
// sfba_divider
// restoring divider, one quotient bit a cycle, signed saturated result
// ----------------------------------------------------------------------------
module sfba_divider (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sfba_pkg::div_req_t  req_i,
  output sfba_pkg::div_rsp_t  rsp_o
);
  import sfba_pkg::*;

  logic [DIV_CNT_W-1:0]  cnt_q;
  logic                  run_q;
  logic                  done_q;
  logic                  neg_q;
  logic [COORD_W-1:0]    rem_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [COORD_W-1:0]    den_q;

  logic [COORD_W:0]      shifted;
  logic                  fits;
  logic [COORD_W:0]      diff;

  assign shifted = {rem_q, quo_q[DIVIDEND_W-1]};
  assign fits    = shifted >= {1'b0, den_q};
  assign diff    = shifted - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        run_q <= 1'b1;
        cnt_q <= DIV_CNT_W'(DIVIDEND_W);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      den_q <= req_i.divisor;
      neg_q <= req_i.neg;
    end else if (run_q) begin
      rem_q <= fits ? diff[COORD_W-1:0] : shifted[COORD_W-1:0];
      quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
    end
  end

  // saturate magnitude against the signed result range
  logic pos_sat;
  logic neg_sat;
  assign pos_sat = |quo_q[DIVIDEND_W-1:BOUND_W-1];
  assign neg_sat = (|quo_q[DIVIDEND_W-1:BOUND_W]) ||
                   (quo_q[BOUND_W-1] && (|quo_q[BOUND_W-2:0]));

  always_comb begin
    rsp_o.done = done_q;
    if (neg_q) begin
      rsp_o.quotient = neg_sat ? BOUND_MIN : -$signed(quo_q[BOUND_W-1:0]);
    end else begin
      rsp_o.quotient = pos_sat ? BOUND_MAX : $signed(quo_q[BOUND_W-1:0]);
    end
  end

endmodule

// ===== rtl/sky_face_bounds_accumulator.sv =====
// ----------------------------------------------------------------------------
// sky_face_bounds_accumulator
// cube face selection and projected s/t bounds of buffered polygons
// ----------------------------------------------------------------------------
// Vertices are written into a 64 entry buffer one word per cycle while busy is
// low. Clear and add without the last flag give no result and leave busy low;
// a read gives its result in the cycle after acceptance. The last vertex of a
// polygon raises busy: the sequencer walks the buffer twice, first summing the
// vertices (states SUM_RD and SUM_ACC for each), then projecting each one
// through a single shared serial divider that yields one quotient bit a cycle
// (44 quotient bits, two divisions per vertex). A vertex whose depth is not
// above DEPTH_MIN skips both divisions. The result strobe res_valid_o is high
// for exactly one cycle, the first cycle with busy low, and the receiver
// cannot stall it, so it must take
// each word as it appears.
// ----------------------------------------------------------------------------
module sky_face_bounds_accumulator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  sfba_pkg::in_word_t  cmd_i,
  output logic                busy,
  output logic                res_valid_o,
  output sfba_pkg::out_word_t res_o
);
  import sfba_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_PICK,
    ST_PROJ_RD,
    ST_PROJ_LD,
    ST_DIV_S,
    ST_DIV_T,
    ST_UPD,
    ST_EMIT
  } state_e;

  state_e                    state_q;
  logic [CNT_W-1:0]          count_q;
  logic [CNT_W-1:0]          idx_q;
  logic                      ovf_q;
  logic signed [SUM_W-1:0]   sum_x_q, sum_y_q, sum_z_q;
  logic [2:0]                face_q;
  logic signed [PICK_W-1:0]  tnum_q;
  logic signed [BOUND_W-1:0] s_q;
  bounds_t                   bounds_q [NUM_FACES];
  logic                      res_valid_q;
  out_word_t                 res_q;
  div_req_t                  div_req_q;
  div_rsp_t                  div_rsp;

  // vertex buffer
  logic    accept;
  logic    wr_en;
  vertex_t wr_vertex;
  vertex_t rd_vertex;

  assign accept    = start && (state_q == ST_IDLE);
  assign wr_en     = accept && (cmd_i.opcode == OP_ADD) &&
                     (count_q < CNT_W'(MAX_VERTICES));
  assign wr_vertex = '{x: cmd_i.coord_x, y: cmd_i.coord_y, z: cmd_i.coord_z};

  sfba_vertex_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (count_q[ADDR_W-1:0]),
    .wdata_i (wr_vertex),
    .raddr_i (idx_q[ADDR_W-1:0]),
    .rdata_o (rd_vertex)
  );

  sfba_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .rsp_o  (div_rsp)
  );

  // magnitudes of the summed vector for the face choice
  logic [SUM_W-1:0] mag_x, mag_y, mag_z;
  logic [2:0]       face_pick;
  assign mag_x = sum_x_q[SUM_W-1] ? SUM_W'(-sum_x_q) : SUM_W'(sum_x_q);
  assign mag_y = sum_y_q[SUM_W-1] ? SUM_W'(-sum_y_q) : SUM_W'(sum_y_q);
  assign mag_z = sum_z_q[SUM_W-1] ? SUM_W'(-sum_z_q) : SUM_W'(sum_z_q);

  always_comb begin
    priority if (mag_x > mag_y && mag_x > mag_z) begin
      face_pick = {2'd0, sum_x_q[SUM_W-1]};
    end else if (mag_y > mag_z && mag_y > mag_x) begin
      face_pick = {2'd1, sum_y_q[SUM_W-1]};
    end else begin
      face_pick = {2'd2, sum_z_q[SUM_W-1]};
    end
  end

  // per-vertex projection operands for the chosen face
  logic signed [PICK_W-1:0] depth, snum, tnum;
  logic [COORD_W-1:0]       snum_mag, tnum_mag;
  assign depth    = pick_coord(rd_vertex, proj_col(face_q, 2'd2));
  assign snum     = pick_coord(rd_vertex, proj_col(face_q, 2'd0));
  assign tnum     = pick_coord(rd_vertex, proj_col(face_q, 2'd1));
  assign snum_mag = snum[PICK_W-1] ? COORD_W'(-snum) : COORD_W'(snum);
  assign tnum_mag = tnum_q[PICK_W-1] ? COORD_W'(-tnum_q) : COORD_W'(tnum_q);

  logic last_idx;
  assign last_idx = (idx_q + 1'b1) == count_q;

  bounds_t cur_b;
  bounds_t new_b;
  assign cur_b = bounds_q[face_q];

  always_comb begin
    new_b = cur_b;
    if (s_q < cur_b.s_low)              new_b.s_low  = s_q;
    if (div_rsp.quotient < cur_b.t_low)  new_b.t_low  = div_rsp.quotient;
    if (s_q > cur_b.s_high)             new_b.s_high = s_q;
    if (div_rsp.quotient > cur_b.t_high) new_b.t_high = div_rsp.quotient;
  end

  logic [2:0] read_face;
  assign read_face = (cmd_i.face_select > FACE_LAST) ? FACE_LAST : cmd_i.face_select;

  function automatic out_word_t make_out(input logic [2:0] f, input bounds_t b,
                                         input logic ovf);
    out_word_t o;
    o.face     = f;
    o.s_low    = b.s_low;
    o.t_low    = b.t_low;
    o.s_high   = b.s_high;
    o.t_high   = b.t_high;
    o.visible  = (b.s_low < b.s_high) && (b.t_low < b.t_high);
    o.overflow = ovf;
    return o;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      ovf_q       <= 1'b0;
      res_valid_q <= 1'b0;
      div_req_q   <= '0;
      for (int f = 0; f < NUM_FACES; f++) begin
        bounds_q[f] <= '{BOUND_MAX, BOUND_MAX, BOUND_MIN, BOUND_MIN};
      end
    end else begin
      res_valid_q     <= 1'b0;
      div_req_q.start <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            unique case (cmd_i.opcode)
              OP_ADD: begin
                if (wr_en) begin
                  count_q <= count_q + 1'b1;
                end else begin
                  ovf_q <= 1'b1;
                end
                if (cmd_i.last_vertex) begin
                  idx_q   <= '0;
                  sum_x_q <= '0;
                  sum_y_q <= '0;
                  sum_z_q <= '0;
                  state_q <= ST_SUM_RD;
                end
              end
              OP_CLEAR: begin
                for (int f = 0; f < NUM_FACES; f++) begin
                  bounds_q[f] <= '{BOUND_MAX, BOUND_MAX, BOUND_MIN, BOUND_MIN};
                end
              end
              OP_READ: begin
                res_valid_q <= 1'b1;
                res_q       <= make_out(read_face, bounds_q[read_face], 1'b0);
              end
              default: ;
            endcase
          end
        end
        ST_SUM_RD: state_q <= ST_SUM_ACC;
        ST_SUM_ACC: begin
          sum_x_q <= sum_x_q + SUM_W'(rd_vertex.x);
          sum_y_q <= sum_y_q + SUM_W'(rd_vertex.y);
          sum_z_q <= sum_z_q + SUM_W'(rd_vertex.z);
          idx_q   <= idx_q + 1'b1;
          state_q <= last_idx ? ST_PICK : ST_SUM_RD;
        end
        ST_PICK: begin
          face_q  <= face_pick;
          idx_q   <= '0;
          state_q <= ST_PROJ_RD;
        end
        ST_PROJ_RD: state_q <= ST_PROJ_LD;
        ST_PROJ_LD: begin
          if (depth > DEPTH_MIN) begin
            div_req_q <= '{start: 1'b1, neg: snum[PICK_W-1],
                           dividend: {snum_mag, FRAC_SHIFT'(0)},
                           divisor: depth[COORD_W-1:0]};
            tnum_q    <= tnum;
            state_q   <= ST_DIV_S;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= last_idx ? ST_EMIT : ST_PROJ_RD;
          end
        end
        ST_DIV_S: begin
          if (div_rsp.done) begin
            s_q       <= div_rsp.quotient;
            div_req_q <= '{start: 1'b1, neg: tnum_q[PICK_W-1],
                           dividend: {tnum_mag, FRAC_SHIFT'(0)},
                           divisor: div_req_q.divisor};
            state_q   <= ST_DIV_T;
          end
        end
        ST_DIV_T: begin
          if (div_rsp.done) begin
            state_q <= ST_UPD;
          end
        end
        ST_UPD: begin
          // divider output holds t until the next start
          bounds_q[face_q] <= new_b;
          idx_q            <= idx_q + 1'b1;
          state_q          <= last_idx ? ST_EMIT : ST_PROJ_RD;
        end
        ST_EMIT: begin
          res_valid_q <= 1'b1;
          res_q       <= make_out(face_q, cur_b, ovf_q);
          count_q     <= '0;
          ovf_q       <= 1'b0;
          state_q     <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy        = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/sfba_checker.sv =====
// ----------------------------------------------------------------------------
// sfba_checker
// port level checks of the face bounds block, bound to the top level
// ----------------------------------------------------------------------------
module sfba_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input sfba_pkg::in_word_t  cmd_i,
  input logic                busy,
  input logic                res_valid_o,
  input sfba_pkg::out_word_t res_o
);
  import sfba_pkg::*;

  // a polygon end always raises busy
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && cmd_i.opcode == OP_ADD && cmd_i.last_vertex |=> busy)
    else $error("last vertex did not start processing");

  // a read answers in the next cycle with the clamped face and no overflow
  a_read_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && cmd_i.opcode == OP_READ |=>
      res_valid_o && !res_o.overflow &&
      res_o.face == (($past(cmd_i.face_select) > FACE_LAST) ?
                     FACE_LAST : $past(cmd_i.face_select)))
    else $error("read result wrong");

  // visible flag matches the reported bounds
  a_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> res_o.visible ==
      ((res_o.s_low < res_o.s_high) && (res_o.t_low < res_o.t_high)))
    else $error("visible flag inconsistent");

  // end of polygon processing delivers its word
  a_done_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> res_valid_o && res_o.face <= FACE_LAST)
    else $error("polygon finished without a result");

endmodule

bind sky_face_bounds_accumulator sfba_checker u_sfba_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .cmd_i       (cmd_i),
  .busy        (busy),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);

// ===== dv/tb_sky_face_bounds_accumulator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sky_face_bounds_accumulator
// self-checking regression of face choice, projection and bound accumulation
// ----------------------------------------------------------------------------
// A behavioural predictor keeps its own vertex buffer and per-face bounds and
// queues one expected word for every read and every closing vertex. A monitor
// compares each strobed result word with the oldest expectation, field by
// field. Directed tests cover extremes and special cases, then random polygons
// with bursty sender timing make up the bulk of the run.
// ----------------------------------------------------------------------------
module tb_sky_face_bounds_accumulator;
  import sfba_pkg::*;

  localparam int  CYCLE_LIMIT = 2_000_000;
  localparam int  TAIL_CYCLES = 200;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  in_word_t  cmd_i;
  logic      busy;
  logic      res_valid_o;
  out_word_t res_o;

  sky_face_bounds_accumulator i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .cmd_i      (cmd_i),
    .busy       (busy),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  // clock
  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // predictor state
  logic signed [COORD_W-1:0] vert_x [MAX_VERTICES];
  logic signed [COORD_W-1:0] vert_y [MAX_VERTICES];
  logic signed [COORD_W-1:0] vert_z [MAX_VERTICES];
  int unsigned               vert_cnt;
  bit                        vert_ovf;
  bounds_t                   face_bnd [NUM_FACES];
  out_word_t                 expected_words [$];
  int                        n_fail;
  longint                    cycle_cnt = 0;
  int                        burst_left;

  function automatic void reset_bounds();
    for (int f = 0; f < NUM_FACES; f++)
      face_bnd[f] = '{BOUND_MAX, BOUND_MAX, BOUND_MIN, BOUND_MIN};
  endfunction

  // column code per face: 1..3 = x..z, negative = negated; col 0 s, 1 t, 2 depth
  function automatic longint face_column(int f, int col, longint x, longint y, longint z);
    int code;
    longint v;
    int tbl [6][3] = '{'{-2, 3, 1}, '{2, 3, -1}, '{1, 3, 2},
                       '{-1, 3, -2}, '{-2, -1, 3}, '{-2, 1, -3}};
    code = tbl[f][col];
    v = ((code < 0 ? -code : code) == 1) ? x : ((code < 0 ? -code : code) == 2) ? y : z;
    return code < 0 ? -v : v;
  endfunction

  function automatic logic signed [BOUND_W-1:0] project_st(longint num, longint den);
    longint q;
    q = (num * 65536) / den;
    if (q > 8388607)  q = 8388607;
    if (q < -8388608) q = -8388608;
    return q[BOUND_W-1:0];
  endfunction

  function automatic out_word_t face_word(int f, bit ovf);
    out_word_t w;
    w.face     = f[2:0];
    w.s_low    = face_bnd[f].s_low;
    w.t_low    = face_bnd[f].t_low;
    w.s_high   = face_bnd[f].s_high;
    w.t_high   = face_bnd[f].t_high;
    w.visible  = (face_bnd[f].s_low < face_bnd[f].s_high) &&
                 (face_bnd[f].t_low < face_bnd[f].t_high);
    w.overflow = ovf;
    return w;
  endfunction

  // model one accepted command word
  function automatic void predict_bounds(in_word_t c);
    longint sx, sy, sz, mx, my, mz, x, y, z, d;
    logic signed [BOUND_W-1:0] s, t;
    int f;
    if (c.opcode == OP_CLEAR) begin
      reset_bounds();
    end else if (c.opcode == OP_READ) begin
      f = (c.face_select > 5) ? 5 : c.face_select;
      expected_words.push_back(face_word(f, 1'b0));
    end else if (c.opcode == OP_ADD) begin
      if (vert_cnt < MAX_VERTICES) begin
        vert_x[vert_cnt] = c.coord_x;
        vert_y[vert_cnt] = c.coord_y;
        vert_z[vert_cnt] = c.coord_z;
        vert_cnt++;
      end else begin
        vert_ovf = 1'b1;
      end
      if (c.last_vertex) begin
        sx = 0; sy = 0; sz = 0;
        for (int i = 0; i < vert_cnt; i++) begin
          sx += vert_x[i]; sy += vert_y[i]; sz += vert_z[i];
        end
        mx = sx < 0 ? -sx : sx;
        my = sy < 0 ? -sy : sy;
        mz = sz < 0 ? -sz : sz;
        if (mx > my && mx > mz)      f = sx < 0 ? 1 : 0;
        else if (my > mz && my > mx) f = sy < 0 ? 3 : 2;
        else                         f = sz < 0 ? 5 : 4;
        for (int i = 0; i < vert_cnt; i++) begin
          x = vert_x[i]; y = vert_y[i]; z = vert_z[i];
          d = face_column(f, 2, x, y, z);
          if (d > 4) begin
            s = project_st(face_column(f, 0, x, y, z), d);
            t = project_st(face_column(f, 1, x, y, z), d);
            if (s < face_bnd[f].s_low)  face_bnd[f].s_low  = s;
            if (t < face_bnd[f].t_low)  face_bnd[f].t_low  = t;
            if (s > face_bnd[f].s_high) face_bnd[f].s_high = s;
            if (t > face_bnd[f].t_high) face_bnd[f].t_high = t;
          end
        end
        expected_words.push_back(face_word(f, vert_ovf));
        vert_cnt = 0;
        vert_ovf = 1'b0;
      end
    end
  endfunction

  // result checker: every strobed word against the oldest expectation
  always @(posedge clk_i) begin
    out_word_t exp_w;
    if (rst_ni && res_valid_o) begin
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: %p", res_o);
        n_fail++;
      end else begin
        exp_w = expected_words.pop_front();
        if (res_o.face !== exp_w.face) begin
          $error("face: expected %0d, got %0d", exp_w.face, res_o.face); n_fail++;
        end
        if (res_o.s_low !== exp_w.s_low) begin
          $error("s_low: expected %0d, got %0d", exp_w.s_low, res_o.s_low); n_fail++;
        end
        if (res_o.t_low !== exp_w.t_low) begin
          $error("t_low: expected %0d, got %0d", exp_w.t_low, res_o.t_low); n_fail++;
        end
        if (res_o.s_high !== exp_w.s_high) begin
          $error("s_high: expected %0d, got %0d", exp_w.s_high, res_o.s_high); n_fail++;
        end
        if (res_o.t_high !== exp_w.t_high) begin
          $error("t_high: expected %0d, got %0d", exp_w.t_high, res_o.t_high); n_fail++;
        end
        if (res_o.visible !== exp_w.visible) begin
          $error("visible: expected %0d, got %0d", exp_w.visible, res_o.visible); n_fail++;
        end
        if (res_o.overflow !== exp_w.overflow) begin
          $error("overflow: expected %0d, got %0d", exp_w.overflow, res_o.overflow);
          n_fail++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("sky_face_bounds_accumulator regression: fail");
      $finish;
    end
  end

  // send one word; bursty gaps before it, held until accepted
  task automatic send_word(in_word_t c);
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 12)) begin
        @(posedge clk_i);
        start <= 1'b0;
        cmd_i <= in_word_t'({$urandom, $urandom, $urandom, $urandom});
      end
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
    end
    burst_left--;
    @(posedge clk_i);
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
    predict_bounds(c);
    start <= 1'b0;
  endtask

  function automatic in_word_t make_word(logic [1:0] op, longint x, longint y, longint z,
                                         bit last, int fs);
    in_word_t c;
    c.opcode      = op;
    c.coord_x     = x[COORD_W-1:0];
    c.coord_y     = y[COORD_W-1:0];
    c.coord_z     = z[COORD_W-1:0];
    c.last_vertex = last;
    c.face_select = fs[2:0];
    return c;
  endfunction

  function automatic longint rand_coord();
    logic [COORD_W-1:0] r;
    r = COORD_W'($urandom);
    case ($urandom_range(0, 3))
      0: return $signed(r);
      1: return $signed(r) >>> $urandom_range(4, 20);
      2: return longint'($urandom_range(0, 10)) - 5;
      default: return $urandom_range(0, 1) ? 134217727 : -134217728;
    endcase
  endfunction

  task automatic read_all_faces();
    for (int f = 0; f < 8; f++) send_word(make_word(OP_READ, 0, 0, 0, 0, f));
  endtask

  // extremes, every operation, tiny depth and tie-breaks
  task automatic test_directed();
    read_all_faces();
    send_word(make_word(OP_ADD, 134217727, 0, 0, 1, 0));              // +x alone
    send_word(make_word(OP_ADD, -134217728, 134217727, -134217728, 1, 0));
    send_word(make_word(OP_ADD, 4096, 4096, 4096, 1, 0));             // full tie: z
    send_word(make_word(OP_ADD, 100, -8192, -8192, 1, 0));            // y,z tie
    send_word(make_word(OP_ADD, 4, 1, 1, 0, 0));                      // depth at limit
    send_word(make_word(OP_ADD, 5, -134217728, 134217727, 0, 0));     // saturates
    send_word(make_word(OP_ADD, 134217727, 3, 3, 1, 0));
    send_word(make_word(OP_ADD, 0, 0, 0, 1, 0));
    send_word(make_word(OP_ADD, 3, 3, -40000, 0, 0));
    send_word(make_word(2'd3, 1, 2, 3, 1, 7));                        // unused opcode
    send_word(make_word(OP_CLEAR, 0, 0, 0, 0, 0));                    // mid polygon
    send_word(make_word(OP_ADD, -5, 2, -30000, 1, 0));
    read_all_faces();
  endtask

  // polygon longer than the buffer
  task automatic test_overflow();
    for (int i = 0; i < MAX_VERTICES + 3; i++)
      send_word(make_word(OP_ADD, rand_coord(), rand_coord(), rand_coord(),
                          i == MAX_VERTICES + 2, 0));
    send_word(make_word(OP_ADD, 8000, 100, -100, 1, 0));              // flag cleared
  endtask

  // random polygons with occasional clears, reads and noise
  task automatic test_random(int n_words);
    int sent;
    int n_vert;
    sent = 0;
    while (sent < n_words) begin
      case ($urandom_range(0, 9))
        0: begin send_word(make_word(OP_READ, rand_coord(), 0, 0, $urandom, $urandom));
           sent++; end
        1: begin send_word(make_word($urandom_range(0, 1) ? OP_CLEAR : 2'd3, rand_coord(),
                                     rand_coord(), rand_coord(), $urandom, $urandom));
           sent++; end
        default: begin
          n_vert = ($urandom_range(0, 30) == 0) ? $urandom_range(20, 66)
                                                : $urandom_range(1, 6);
          for (int i = 0; i < n_vert; i++)
            send_word(make_word(OP_ADD, rand_coord(), rand_coord(), rand_coord(),
                                i == n_vert - 1, $urandom));
          sent += n_vert;
        end
      endcase
    end
  endtask

  initial begin
    rst_ni     = 1'b0;
    start      = 1'b0;
    cmd_i      = '0;
    n_fail     = 0;
    burst_left = 0;
    vert_cnt   = 0;
    vert_ovf   = 1'b0;
    reset_bounds();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_overflow();
    test_random(1300);
    read_all_faces();
    @(posedge clk_i);
    while (expected_words.size() != 0 || busy) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (n_fail == 0 && expected_words.size() == 0)
      $display("sky_face_bounds_accumulator regression: pass");
    else
      $display("sky_face_bounds_accumulator regression: fail");
    $finish;
  end
endmodule
